>>> hw/rtl/sorted_key_successor_pair_matcher_assert.svh
// Assertion macros for the successor pair matcher.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef SORTED_KEY_SUCCESSOR_PAIR_MATCHER_ASSERT_SVH
`define SORTED_KEY_SUCCESSOR_PAIR_MATCHER_ASSERT_SVH

// Property that must hold in the same cycle.
`define SKSPM_ASSERT_NOW(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define SKSPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/skspm_pkg.sv
// -----------------------------------------------------------------------------
// skspm_pkg
// Shared widths, limits and controller/datapath interface types.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package skspm_pkg;

  localparam int KeyW     = 32;
  localparam int PosW     = 20;              // table positions
  localparam int NextPosW = PosW + 1;        // position counter incl. full flag
  localparam int MaxGroup = 64;              // members recorded per run
  localparam int CntW     = $clog2(MaxGroup) + 1;
  localparam int IdxW     = $clog2(MaxGroup);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EMIT
  } skspm_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic accept;   // take the input item, update runs, latch pair group
    logic emit;     // load the next pair into the output register
  } skspm_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic hit;        // the presented key forms at least one pair
    logic last;       // the pair about to be emitted is the final one
    logic slot_free;  // output register can take a pair this cycle
  } skspm_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/sorted_key_successor_pair_matcher.sv
// An accepted key latches its pair group; the emit sequencer then loads the pairs
//   into the output register, from which they transfer out.
// Each key forms N pairs (0 to 64); the input stays closed while they are emitted, one
//   pair per cycle from the emit sequencer unless the output side stalls.
// The output register lets the next key be taken while the final pair waits.
// Reset: asynchronous, active low; clears positions, both runs and all valids.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_key_successor_pair_matcher_assert.svh"
// -----------------------------------------------------------------------------
// sorted_key_successor_pair_matcher
// Joins sorted table keys with their successors: for each key equal to the
// prior run's key plus one, transfer one (left, right) pair per run member.
// -----------------------------------------------------------------------------

module sorted_key_successor_pair_matcher (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // key input channel
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [skspm_pkg::KeyW-1:0] key_value_i,
  input  wire logic                       first_of_table_i,
  // pair output channel
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [skspm_pkg::PosW-1:0]      left_index_o,
  output logic [skspm_pkg::PosW-1:0]      right_index_o,
  output logic                            last_pair_o,
  output logic                            group_overflow_o
);
  import skspm_pkg::*;

  skspm_cmd_t cmd;
  skspm_sts_t sts;

  // Controller: idle takes keys, emit state walks the matched run.
  skspm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: run registers, pair group latch and output register.
  skspm_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .key_value_i      (key_value_i),
    .first_of_table_i (first_of_table_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .left_index_o     (left_index_o),
    .right_index_o    (right_index_o),
    .last_pair_o      (last_pair_o),
    .group_overflow_o (group_overflow_o)
  );

  // Never load a pair over one that is still waiting.
  `SKSPM_ASSERT_NOW(a_no_overwrite, !(cmd.emit && out_valid_o && !out_ready_i), "pair overwritten")
  // Input stays closed while a pair group is in flight.
  `SKSPM_ASSERT_NOW(a_no_accept_in_emit, !(cmd.emit && in_ready_o), "accept during emit")
  // A matching key stops further input on the next cycle.
  `SKSPM_ASSERT_NEXT(a_hit_blocks, in_valid_i && in_ready_o && sts.hit, !in_ready_o, "hit lost")
  // The final pair hands control back to the input side.
  `SKSPM_ASSERT_NEXT(a_last_returns, cmd.emit && sts.last, in_ready_o && last_pair_o, "no return")

endmodule

`default_nettype wire

>>> hw/rtl/skspm_ctrl.sv
// -----------------------------------------------------------------------------
// skspm_ctrl
// Controller: accepts keys when idle and sequences pair emission.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module skspm_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire skspm_pkg::skspm_sts_t sts_i,
  output skspm_pkg::skspm_cmd_t   cmd_o
);
  import skspm_pkg::*;

  skspm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && sts_i.hit) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // one pair per free output slot; return once the final one is loaded
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/skspm_datapath.sv
// -----------------------------------------------------------------------------
// skspm_datapath
// Run tracking registers, pair group latch and output register.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module skspm_datapath (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [skspm_pkg::KeyW-1:0]   key_value_i,
  input  wire logic                         first_of_table_i,
  input  wire skspm_pkg::skspm_cmd_t        cmd_i,
  output skspm_pkg::skspm_sts_t             sts_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [skspm_pkg::PosW-1:0]        left_index_o,
  output logic [skspm_pkg::PosW-1:0]        right_index_o,
  output logic                              last_pair_o,
  output logic                              group_overflow_o
);
  import skspm_pkg::*;

  // run state
  logic [NextPosW-1:0] next_pos_q, next_pos_d;
  logic [KeyW-1:0]     run_key_q, run_key_d, prior_key_q, prior_key_d;
  logic [PosW-1:0]     run_start_q, run_start_d, prior_start_q, prior_start_d;
  logic [CntW-1:0]     run_count_q, run_count_d, prior_count_q, prior_count_d;
  logic                run_sat_q, run_sat_d, prior_sat_q, prior_sat_d;

  // effective state after an optional table restart
  logic [NextPosW-1:0] np_eff;
  logic [KeyW-1:0]     rk_eff, pk_eff;
  logic [PosW-1:0]     rs_eff, ps_eff;
  logic [CntW-1:0]     rc_eff, pc_eff;
  logic                rsat_eff, psat_eff;
  logic                full, same_run, hit;

  // pair group being emitted
  logic [PosW-1:0]     grp_start_q, grp_right_q;
  logic [CntW-1:0]     grp_count_q;
  logic                grp_sat_q;
  logic [IdxW-1:0]     grp_idx_q;
  logic                grp_last;

  // output register
  logic                out_valid_q;
  logic [PosW-1:0]     left_q, right_q;
  logic                last_q, ovf_q;

  always_comb begin
    np_eff   = first_of_table_i ? '0 : next_pos_q;
    rk_eff   = first_of_table_i ? '0 : run_key_q;
    rs_eff   = first_of_table_i ? '0 : run_start_q;
    rc_eff   = first_of_table_i ? '0 : run_count_q;
    rsat_eff = first_of_table_i ? 1'b0 : run_sat_q;
    pk_eff   = first_of_table_i ? '0 : prior_key_q;
    ps_eff   = first_of_table_i ? '0 : prior_start_q;
    pc_eff   = first_of_table_i ? '0 : prior_count_q;
    psat_eff = first_of_table_i ? 1'b0 : prior_sat_q;

    // table full once the counter reaches the entry limit
    full       = np_eff[PosW];
    next_pos_d = np_eff + NextPosW'(1);
    same_run   = (rc_eff != '0) && (key_value_i == rk_eff);

    if (same_run) begin
      prior_key_d   = pk_eff;
      prior_start_d = ps_eff;
      prior_count_d = pc_eff;
      prior_sat_d   = psat_eff;
      run_key_d     = rk_eff;
      run_start_d   = rs_eff;
      if (rc_eff < CntW'(MaxGroup)) begin
        run_count_d = rc_eff + CntW'(1);
        run_sat_d   = rsat_eff;
      end else begin
        run_count_d = rc_eff;
        run_sat_d   = 1'b1;
      end
    end else begin
      // close the current run; it becomes the prior run
      prior_key_d   = rk_eff;
      prior_start_d = rs_eff;
      prior_count_d = rc_eff;
      prior_sat_d   = rsat_eff;
      run_key_d     = key_value_i;
      run_start_d   = np_eff[PosW-1:0];
      run_count_d   = CntW'(1);
      run_sat_d     = 1'b0;
    end

    // successor test without wrap at the top key
    hit = !full && (prior_count_d != '0) &&
          (({1'b0, prior_key_d} + (KeyW+1)'(1)) == {1'b0, key_value_i});
  end

  assign grp_last = (({1'b0, grp_idx_q} + CntW'(1)) == grp_count_q);

  assign sts_o.hit       = hit;
  assign sts_o.last      = grp_last;
  assign sts_o.slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_pos_q    <= '0;
      run_key_q     <= '0;
      run_start_q   <= '0;
      run_count_q   <= '0;
      run_sat_q     <= 1'b0;
      prior_key_q   <= '0;
      prior_start_q <= '0;
      prior_count_q <= '0;
      prior_sat_q   <= 1'b0;
    end else if (cmd_i.accept && !full) begin
      next_pos_q    <= next_pos_d;
      run_key_q     <= run_key_d;
      run_start_q   <= run_start_d;
      run_count_q   <= run_count_d;
      run_sat_q     <= run_sat_d;
      prior_key_q   <= prior_key_d;
      prior_start_q <= prior_start_d;
      prior_count_q <= prior_count_d;
      prior_sat_q   <= prior_sat_d;
    end
  end

  // pair group latch, payload only
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      grp_start_q <= prior_start_d;
      grp_right_q <= np_eff[PosW-1:0];
      grp_count_q <= prior_count_d;
      grp_sat_q   <= prior_sat_d;
      grp_idx_q   <= '0;
    end else if (cmd_i.emit) begin
      grp_idx_q   <= grp_idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      left_q  <= grp_start_q + PosW'(grp_idx_q);
      right_q <= grp_right_q;
      last_q  <= grp_last;
      ovf_q   <= grp_sat_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign left_index_o     = left_q;
  assign right_index_o    = right_q;
  assign last_pair_o      = last_q;
  assign group_overflow_o = ovf_q;

endmodule

`default_nettype wire

>>> tb/tb_sorted_key_successor_pair_matcher.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Successor pair matcher testbench
// Sends sorted table keys and checks every (left, right) pair against a
// behavioral join model kept in the bench or against a pair typed into
// the directed table, which covers reset state, key extremes, top-key
// wrap, unsorted keys, table restart and group saturation. Random tables
// and noise then run with random idling on both channels.
// -----------------------------------------------------------------------------

module tb_sorted_key_successor_pair_matcher;
  import skspm_pkg::*;

  localparam int ClkPeriod   = 8;
  localparam int ResetCycles = 9;
  localparam int TableSize   = 1 << PosW;
  localparam int RandomKeys  = 110;
  localparam int IdlePct     = 38;
  // A few hundred keys of at most 64 pairs each, stretched by stalls, stay
  // far below this.
  localparam int CycleLimit  = 200_000;

  typedef struct packed {
    logic [PosW-1:0] left;
    logic [PosW-1:0] right;
    logic            last;
    logic            ovf;
  } join_pair_t;

  // One row of the directed table. A negative typed count means the join
  // model supplies the pairs; otherwise the row carries them itself.
  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic              first;
    logic [7:0]        reps;
    logic signed [7:0] n_typed;
    join_pair_t        pair;
  } key_row_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [KeyW-1:0] key_value = '0;
  logic            first_of_table = 1'b0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [PosW-1:0] left_index;
  logic [PosW-1:0] right_index;
  logic            last_pair;
  logic            group_overflow;

  // Join model state: position counter plus the current and prior runs.
  logic [NextPosW-1:0] tbl_next = '0;
  logic [KeyW-1:0]     run_key = '0;
  logic [PosW-1:0]     run_start = '0;
  logic [CntW-1:0]     run_cnt = '0;
  logic                run_sat = 1'b0;
  logic [KeyW-1:0]     prior_key = '0;
  logic [PosW-1:0]     prior_start = '0;
  logic [CntW-1:0]     prior_cnt = '0;
  logic                prior_sat = 1'b0;

  join_pair_t fresh_pairs[$];
  join_pair_t pairs_due[$];
  key_row_t   dir_rows[$];

  bit calm = 1'b0;
  bit drained_once = 1'b0;
  int keys_sent = 0;
  int random_keys = 0;
  int pairs_seen = 0;
  int fail_count = 0;
  int cycle_count = 0;

  sorted_key_successor_pair_matcher uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .key_value_i     (key_value),
    .first_of_table_i(first_of_table),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .left_index_o    (left_index),
    .right_index_o   (right_index),
    .last_pair_o     (last_pair),
    .group_overflow_o(group_overflow)
  );

  initial begin
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // Advance the join model by one accepted key and leave its pairs in
  // fresh_pairs, ascending left order, last one flagged.
  task automatic advance_join(input logic [KeyW-1:0] key, input logic first);
    logic [PosW-1:0] pos;
    join_pair_t      p;
    fresh_pairs.delete();
    if (first) begin
      tbl_next  = '0;
      run_key   = '0;
      run_start = '0;
      run_cnt   = '0;
      run_sat   = 1'b0;
      prior_key   = '0;
      prior_start = '0;
      prior_cnt   = '0;
      prior_sat   = 1'b0;
    end
    // A full table drops the key without touching the runs.
    if (tbl_next < TableSize) begin
      pos      = tbl_next[PosW-1:0];
      tbl_next = tbl_next + 1'b1;
      if (run_cnt != 0 && key == run_key) begin
        if (run_cnt < MaxGroup) run_cnt = run_cnt + 1'b1;
        else run_sat = 1'b1;
      end else begin
        // Any other key, smaller ones too, closes the current run.
        prior_key   = run_key;
        prior_start = run_start;
        prior_cnt   = run_cnt;
        prior_sat   = run_sat;
        run_key     = key;
        run_start   = pos;
        run_cnt     = CntW'(1);
        run_sat     = 1'b0;
      end
      // Successor test is done one bit wider so the top key never wraps to 0.
      if (prior_cnt != 0 && {1'b0, prior_key} + 33'd1 == {1'b0, key}) begin
        for (int i = 0; i < prior_cnt; i++) begin
          p.left  = prior_start + i[PosW-1:0];
          p.right = pos;
          p.last  = (i == prior_cnt - 1);
          p.ovf   = prior_sat;
          fresh_pairs = {fresh_pairs, p};
        end
      end
    end
  endtask

  // Present one key, hold it until the transfer, then log its pairs.
  task automatic send_key(input logic [KeyW-1:0] key, input logic first,
                          input int n_typed, input join_pair_t typed);
    while (!calm && $urandom_range(99, 0) < IdlePct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    key_value      <= key;
    first_of_table <= first;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    keys_sent++;
    advance_join(key, first);
    if (n_typed < 0) begin
      pairs_due = {pairs_due, fresh_pairs};
    end else if (n_typed == 1) begin
      pairs_due = {pairs_due, typed};
    end
  endtask

  // Drop valid and hold off until every pending pair has been transferred.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pairs_due.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(input logic [KeyW-1:0] key, input logic first, input int reps,
                         input int n_typed, input int left, input int right);
    key_row_t row;
    row.key        = key;
    row.first      = first;
    row.reps       = 8'(reps);
    row.n_typed    = 8'(n_typed);
    row.pair.left  = PosW'(left);
    row.pair.right = PosW'(right);
    row.pair.last  = 1'b1;
    row.pair.ovf   = 1'b0;
    dir_rows = {dir_rows, row};
  endtask

  task automatic build_rows();
    // Straight out of reset: positions from 0, both runs empty.
    add_row(32'h0000_0000, 1'b0, 1,  0, 0, 0);
    add_row(32'h0000_0001, 1'b0, 1,  1, 0, 1);
    add_row(32'h0000_0001, 1'b0, 1,  1, 0, 2);   // equal key still pairs with prior
    add_row(32'h0000_0002, 1'b0, 1, -1, 0, 0);
    // Top key: a run at all-ones never matches a following zero.
    add_row(32'hFFFF_FFFF, 1'b1, 1,  0, 0, 0);
    add_row(32'h0000_0000, 1'b0, 1,  0, 0, 0);
    add_row(32'h0000_0001, 1'b0, 1,  1, 1, 2);
    // Restart must clear the run that would otherwise match.
    add_row(32'h0000_0002, 1'b1, 1,  0, 0, 0);
    add_row(32'h7FFF_FFFF, 1'b0, 1,  0, 0, 0);
    add_row(32'h8000_0000, 1'b0, 1,  1, 1, 2);
    // Run of exactly the group limit: full set of pairs, no overflow.
    add_row(32'h1234_5678, 1'b1, MaxGroup, 0, 0, 0);
    add_row(32'h1234_5679, 1'b0, 1, -1, 0, 0);
    // Run beyond the group limit: saturated, overflow on every pair it forms.
    add_row(32'hA5A5_A5A5, 1'b1, 70, 0, 0, 0);
    add_row(32'hA5A5_A5A6, 1'b0, 2, -1, 0, 0);
    add_row(32'hA5A5_A5A7, 1'b0, 1, -1, 0, 0);
    add_row(32'h5A5A_5A5A, 1'b1, 3,  0, 0, 0);
    add_row(32'h5A5A_5A5B, 1'b0, 3, -1, 0, 0);
    // Unsorted: a smaller key closes the run and can still be matched.
    add_row(32'h5A5A_5A5D, 1'b0, 1, -1, 0, 0);
    add_row(32'h5A5A_5A5C, 1'b0, 1, -1, 0, 0);
    add_row(32'h5A5A_5A5D, 1'b0, 1, -1, 0, 0);
    add_row(32'hFFFF_FFFE, 1'b1, 1,  0, 0, 0);
    add_row(32'hFFFF_FFFF, 1'b0, 2, -1, 0, 0);
    add_row(32'h0000_0000, 1'b0, 1,  0, 0, 0);
  endtask

  // Well-formed table: restart, then ascending runs, mostly successors.
  task automatic random_table();
    logic [KeyW-1:0] k;
    int              groups;
    int              len;
    int              roll;
    k      = ($urandom_range(9, 0) == 0) ? 32'hFFFF_FFFF - $urandom_range(20, 0) : $urandom();
    groups = $urandom_range(8, 2);
    for (int g = 0; g < groups; g++) begin
      len = ($urandom_range(49, 0) == 0) ? $urandom_range(70, 60) : $urandom_range(4, 1);
      for (int r = 0; r < len; r++) begin
        send_key(k, g == 0 && r == 0, -1, '0);
        random_keys++;
      end
      roll = $urandom_range(99, 0);
      if (roll < 65) k = k + 1;
      else if (roll < 85) k = k + $urandom_range(3, 2);
      else k = k + $urandom();
    end
  endtask

  // Noise: arbitrary keys, out of order, with the odd stray restart.
  task automatic random_noise();
    int cnt;
    cnt = $urandom_range(6, 1);
    for (int i = 0; i < cnt; i++) begin
      send_key($urandom(), $urandom_range(9, 0) == 0, -1, '0);
      random_keys++;
    end
  endtask

  // Receiver side: stall at random, except in calm stretches.
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99, 0) >= IdlePct);
  end

  // Compare each transferred pair against the oldest pending one.
  always @(posedge clk) begin : check_pairs
    join_pair_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pairs_due.size() == 0) begin
        $error("unexpected pair: left_index %0h right_index %0h", left_index, right_index);
        fail_count++;
      end else begin
        want = pairs_due.pop_front();
        pairs_seen++;
        if (left_index !== want.left) begin
          $error("left_index: expected %0h, got %0h", want.left, left_index);
          fail_count++;
        end
        if (right_index !== want.right) begin
          $error("right_index: expected %0h, got %0h", want.right, right_index);
          fail_count++;
        end
        if (last_pair !== want.last) begin
          $error("last_pair: expected %0b, got %0b", want.last, last_pair);
          fail_count++;
        end
        if (group_overflow !== want.ovf) begin
          $error("group_overflow: expected %0b, got %0b", want.ovf, group_overflow);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d pairs pending", cycle_count, pairs_due.size());
      $display("sorted_key_successor_pair_matcher test failed");
      $finish;
    end
  end

  initial begin
    build_rows();
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table; only the first copy of a row restarts.
    foreach (dir_rows[i]) begin
      for (int r = 0; r < dir_rows[i].reps; r++) begin
        send_key(dir_rows[i].key, dir_rows[i].first && r == 0, int'(dir_rows[i].n_typed),
                 dir_rows[i].pair);
      end
    end
    hold_until_drained();

    // Random tables, each with a restart, mixed with noise; the first is always
    // a table. Run one calm stretch and one full drain along the way.
    while (random_keys < RandomKeys) begin
      calm = (random_keys >= 30 && random_keys < 70);
      if (!drained_once && random_keys >= 80) begin
        hold_until_drained();
        drained_once = 1'b1;
      end
      if (random_keys == 0 || $urandom_range(99, 0) < 85) random_table();
      else random_noise();
    end
    calm = 1'b0;

    hold_until_drained();
    repeat (MaxGroup + 16) @(posedge clk);

    $display("covered %0d key transfers and %0d checked pairs", keys_sent, pairs_seen);
    $display("including group saturation, top-key, unsorted keys and table restarts");
    if (fail_count == 0) begin
      $display("sorted_key_successor_pair_matcher test passed");
    end else begin
      $display("sorted_key_successor_pair_matcher test failed");
    end
    $finish;
  end

endmodule
